// ----- rtl/svpwm_pkg.sv -----
package svpwm_pkg;

    localparam int VOLT_BITS_DEF     = 16;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int DUTY_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int STAGE_MAX         = 24;
    localparam int RECIP_BITS        = 16;

    localparam logic [RECIP_BITS-1:0] RECIP_RESET = 16'd5461;

    localparam logic [31:0] TURN_QUARTER  = 32'h4000_0000;
    localparam logic [31:0] TURN_HALF     = 32'h8000_0000;
    localparam logic [31:0] TURN_3QUARTER = 32'hC000_0000;

    localparam logic [15:0] INVK_Q16 = 16'd39797;
    localparam logic signed [32:0] INVK_Q30 = 33'sd652032874;
    localparam logic [30:0] K_1P5_Q30 = 31'd1610612736;
    localparam logic [30:0] K_S3H_Q30 = 31'd929887697;
    localparam logic [30:0] K_S3_Q30  = 31'd1859775393;

    // floor(r / 6) = (r * RECIP6) >> 34 for any 32-bit r
    localparam logic [31:0] RECIP6 = 32'hAAAA_AAAB;

    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } t_sector;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051E;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2FA;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/svpwm_vec_cordic.sv -----
module svpwm_vec_cordic #(
    parameter int VOLT_BITS  = svpwm_pkg::VOLT_BITS_DEF,
    parameter int ANGLE_BITS = svpwm_pkg::ANGLE_BITS_DEF,
    parameter int STAGES     = svpwm_pkg::CORDIC_STAGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic signed [VOLT_BITS-1:0] i_volt_q,
    input  logic signed [VOLT_BITS-1:0] i_volt_d,
    input  logic [ANGLE_BITS-1:0]       i_theta,
    output logic                        o_valid,
    output logic                        o_d_zero,
    output logic signed [VOLT_BITS-1:0] o_volt_q,
    output logic [ANGLE_BITS-1:0]       o_theta,
    output logic [VOLT_BITS+9:0]        o_x,
    output logic [31:0]                 o_z
);

    localparam int XW = VOLT_BITS + 11;
    localparam int N  = (STAGES < svpwm_pkg::STAGE_MAX) ? STAGES : svpwm_pkg::STAGE_MAX;

    logic signed [XW-1:0]        r_x     [N+1];
    logic signed [XW-1:0]        r_y     [N+1];
    logic [31:0]                 r_z     [N+1];
    logic                        r_valid [N+1];
    logic                        r_dz    [N+1];
    logic signed [VOLT_BITS-1:0] r_vq    [N+1];
    logic [ANGLE_BITS-1:0]       r_th    [N+1];

    logic signed [XW-1:0] w_xin, w_yin, n_x0, n_y0;
    logic [31:0]          n_z0;

    assign w_xin = XW'(i_volt_d) <<< 8;
    assign w_yin = XW'(i_volt_q) <<< 8;

    // fold the left half plane onto the right
    always_comb begin
        n_x0 = w_xin;
        n_y0 = w_yin;
        n_z0 = '0;
        if (w_xin < 0) begin
            n_x0 = -w_xin;
            n_y0 = -w_yin;
            n_z0 = svpwm_pkg::TURN_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
        if (i_en) begin
            r_x[0]  <= n_x0;
            r_y[0]  <= n_y0;
            r_z[0]  <= n_z0;
            r_dz[0] <= (i_volt_d == '0);
            r_vq[0] <= i_volt_q;
            r_th[0] <= i_theta;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic signed [XW-1:0] w_dx, w_dy;
        logic [31:0]          w_at;

        assign w_dx = r_y[k] >>> k;
        assign w_dy = r_x[k] >>> k;
        assign w_at = svpwm_pkg::atan_turn(5'(k));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= r_valid[k];
            end
            if (i_en) begin
                if (r_y[k] > 0) begin
                    r_x[k+1] <= r_x[k] + w_dx;
                    r_y[k+1] <= r_y[k] - w_dy;
                    r_z[k+1] <= r_z[k] + w_at;
                end else begin
                    r_x[k+1] <= r_x[k] - w_dx;
                    r_y[k+1] <= r_y[k] + w_dy;
                    r_z[k+1] <= r_z[k] - w_at;
                end
                r_dz[k+1] <= r_dz[k];
                r_vq[k+1] <= r_vq[k];
                r_th[k+1] <= r_th[k];
            end
        end
    end

    assign o_valid  = r_valid[N];
    assign o_d_zero = r_dz[N];
    assign o_volt_q = r_vq[N];
    assign o_theta  = r_th[N];
    assign o_x      = (r_x[N] < 0) ? '0 : r_x[N][XW-2:0];
    assign o_z      = r_z[N];

endmodule

// ----- rtl/svpwm_angle.sv -----
module svpwm_angle #(
    parameter int VOLT_BITS  = svpwm_pkg::VOLT_BITS_DEF,
    parameter int ANGLE_BITS = svpwm_pkg::ANGLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic                               i_d_zero,
    input  logic signed [VOLT_BITS-1:0]        i_volt_q,
    input  logic [ANGLE_BITS-1:0]              i_theta,
    input  logic [VOLT_BITS+9:0]               i_x,
    input  logic [31:0]                        i_z,
    input  logic [svpwm_pkg::RECIP_BITS-1:0]   i_recip,
    output logic                               o_valid,
    output logic [VOLT_BITS+9:0]               o_m,
    output logic [2:0]                         o_sector,
    output logic [29:0]                        o_phi
);

    localparam int MW = VOLT_BITS + 2;
    localparam int PW = VOLT_BITS + 26;
    localparam int RW = MW + svpwm_pkg::RECIP_BITS;

    logic                 r1_valid, r2_valid, r3_valid;
    logic [PW-1:0]        r1_prod;
    logic                 r1_dz;
    logic [VOLT_BITS-1:0] r1_abs;
    logic [31:0]          r1_th;
    logic [RW-1:0]        r2_mp;
    logic [2:0]           r2_sec, r3_sec;
    logic [31:0]          r2_rem;
    logic [VOLT_BITS+9:0] r3_m;
    logic [63:0]          r3_q;

    logic [31:0]          w_off, w_th;
    logic [VOLT_BITS-1:0] w_abs;
    logic [MW-1:0]        w_mag;
    logic [34:0]          w_t6;

    always_comb begin
        if (!i_d_zero) begin
            w_off = i_z;
        end else if (i_volt_q < 0) begin
            w_off = svpwm_pkg::TURN_3QUARTER;
        end else begin
            w_off = svpwm_pkg::TURN_QUARTER;
        end
    end

    assign w_th  = {i_theta, {(32-ANGLE_BITS){1'b0}}} + w_off;
    assign w_abs = i_volt_q[VOLT_BITS-1] ? VOLT_BITS'(-i_volt_q) : VOLT_BITS'(i_volt_q);
    assign w_mag = r1_dz ? MW'(r1_abs) : r1_prod[PW-1:24];
    assign w_t6  = {1'b0, r1_th, 2'b00} + {2'b00, r1_th, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r1_prod <= PW'(i_x) * PW'(svpwm_pkg::INVK_Q16);
            r1_dz   <= i_d_zero;
            r1_abs  <= w_abs;
            r1_th   <= w_th;
            r2_mp   <= RW'(w_mag) * RW'(i_recip);
            r2_sec  <= w_t6[34:32];
            r2_rem  <= w_t6[31:0];
            r3_m    <= r2_mp[RW-1:8];
            r3_q    <= 64'(r2_rem) * 64'(svpwm_pkg::RECIP6);
            r3_sec  <= r2_sec;
        end
    end

    assign o_valid  = r3_valid;
    assign o_m      = r3_m;
    assign o_sector = r3_sec;
    assign o_phi    = r3_q[63:34];

endmodule

// ----- rtl/svpwm_rot_cordic.sv -----
module svpwm_rot_cordic #(
    parameter int VOLT_BITS = svpwm_pkg::VOLT_BITS_DEF,
    parameter int STAGES    = svpwm_pkg::CORDIC_STAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [29:0]          i_phi,
    input  logic [VOLT_BITS+9:0] i_m,
    input  logic [2:0]           i_sector,
    output logic                 o_valid,
    output logic signed [32:0]   o_cos,
    output logic signed [32:0]   o_sin,
    output logic [VOLT_BITS+9:0] o_m,
    output logic [2:0]           o_sector
);

    localparam int N = (STAGES < svpwm_pkg::STAGE_MAX) ? STAGES : svpwm_pkg::STAGE_MAX;

    logic signed [32:0]   r_c     [N+1];
    logic signed [32:0]   r_s     [N+1];
    logic signed [31:0]   r_z     [N+1];
    logic                 r_valid [N+1];
    logic [VOLT_BITS+9:0] r_m     [N+1];
    logic [2:0]           r_sec   [N+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
        if (i_en) begin
            r_c[0]   <= svpwm_pkg::INVK_Q30;
            r_s[0]   <= '0;
            r_z[0]   <= $signed({2'b00, i_phi});
            r_m[0]   <= i_m;
            r_sec[0] <= i_sector;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic signed [32:0] w_dc, w_ds;
        logic signed [31:0] w_at;

        assign w_dc = r_s[k] >>> k;
        assign w_ds = r_c[k] >>> k;
        assign w_at = $signed(svpwm_pkg::atan_turn(5'(k)));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= r_valid[k];
            end
            if (i_en) begin
                if (!r_z[k][31]) begin
                    r_c[k+1] <= r_c[k] - w_dc;
                    r_s[k+1] <= r_s[k] + w_ds;
                    r_z[k+1] <= r_z[k] - w_at;
                end else begin
                    r_c[k+1] <= r_c[k] + w_dc;
                    r_s[k+1] <= r_s[k] - w_ds;
                    r_z[k+1] <= r_z[k] + w_at;
                end
                r_m[k+1]   <= r_m[k];
                r_sec[k+1] <= r_sec[k];
            end
        end
    end

    assign o_valid  = r_valid[N];
    assign o_cos    = r_c[N];
    assign o_sin    = r_s[N];
    assign o_m      = r_m[N];
    assign o_sector = r_sec[N];

endmodule

// ----- rtl/svpwm_duty_calc.sv -----
module svpwm_duty_calc #(
    parameter int VOLT_BITS = svpwm_pkg::VOLT_BITS_DEF,
    parameter int DUTY_BITS = svpwm_pkg::DUTY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [32:0]   i_cos,
    input  logic signed [32:0]   i_sin,
    input  logic [VOLT_BITS+9:0] i_m,
    input  logic [2:0]           i_sector,
    output logic                 o_valid,
    output logic [DUTY_BITS-1:0] o_duty_a,
    output logic [DUTY_BITS-1:0] o_duty_b,
    output logic [DUTY_BITS-1:0] o_duty_c,
    output logic [2:0]           o_sector,
    output logic                 o_over
);

    localparam int PW = 65;
    localparam int UW = 22;
    localparam int TW = VOLT_BITS + 33;
    localparam int SW = TW + 2;

    localparam logic signed [PW:0]   ROUND_Q44 = 66'sd1 <<< 43;
    localparam logic signed [SW-1:0] ONE_Q32   = SW'(65'sd4294967296);
    localparam logic signed [SW-1:0] DUTY_FULL = SW'((65'sd1 <<< DUTY_BITS) - 65'sd1);

    logic                 r1_valid, r2_valid, r3_valid, r4_valid, r5_valid, r6_valid;
    logic signed [PW-1:0] r1_p1, r1_p2, r1_p3;
    logic signed [UW-1:0] r2_u1, r2_u2;
    logic signed [TW-1:0] r3_t1, r3_t2;
    logic signed [SW-1:0] r4_t1, r4_t2, r4_t12, r5_t1, r5_t2, r5_t12, r5_h;
    logic                 r5_over;
    logic [VOLT_BITS+9:0] r1_m, r2_m;
    logic [2:0]           r1_sec, r2_sec, r3_sec, r4_sec, r5_sec;
    logic [DUTY_BITS-1:0] r6_a, r6_b, r6_c;
    logic [2:0]           r6_sec;
    logic                 r6_over;

    logic signed [PW:0]   w_sum1, w_sum2;
    logic signed [SW-1:0] w_t0, w_a, w_b, w_c;
    logic [2:0]           w_sec;

    function automatic logic [DUTY_BITS-1:0] to_duty(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] q;
        logic [DUTY_BITS-1:0] d;
        q = v >>> (32 - DUTY_BITS);
        if (q < 0) begin
            d = '0;
        end else if (q > DUTY_FULL) begin
            d = DUTY_FULL[DUTY_BITS-1:0];
        end else begin
            d = q[DUTY_BITS-1:0];
        end
        return d;
    endfunction

    assign w_sum1 = (PW+1)'(r1_p1) - (PW+1)'(r1_p2) + ROUND_Q44;
    assign w_sum2 = (PW+1)'(r1_p3) + ROUND_Q44;
    assign w_t0   = ONE_Q32 - r4_t12;

    always_comb begin
        w_sec = r5_sec;
        unique case (svpwm_pkg::t_sector'(r5_sec))
            svpwm_pkg::SECTOR_0: begin
                w_a = r5_t12 + r5_h; w_b = r5_t2 + r5_h; w_c = r5_h;
            end
            svpwm_pkg::SECTOR_1: begin
                w_a = r5_t1 + r5_h; w_b = r5_t12 + r5_h; w_c = r5_h;
            end
            svpwm_pkg::SECTOR_2: begin
                w_a = r5_h; w_b = r5_t12 + r5_h; w_c = r5_t2 + r5_h;
            end
            svpwm_pkg::SECTOR_3: begin
                w_a = r5_h; w_b = r5_t1 + r5_h; w_c = r5_t12 + r5_h;
            end
            svpwm_pkg::SECTOR_4: begin
                w_a = r5_t2 + r5_h; w_b = r5_h; w_c = r5_t12 + r5_h;
            end
            default: begin
                w_a = r5_t12 + r5_h; w_b = r5_h; w_c = r5_t1 + r5_h;
                w_sec = svpwm_pkg::SECTOR_5;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
        if (i_en) begin
            r1_p1   <= PW'(i_cos) * PW'($signed({1'b0, svpwm_pkg::K_1P5_Q30}));
            r1_p2   <= PW'(i_sin) * PW'($signed({1'b0, svpwm_pkg::K_S3H_Q30}));
            r1_p3   <= PW'(i_sin) * PW'($signed({1'b0, svpwm_pkg::K_S3_Q30}));
            r1_m    <= i_m;
            r1_sec  <= i_sector;
            r2_u1   <= w_sum1[PW:44];
            r2_u2   <= w_sum2[PW:44];
            r2_m    <= r1_m;
            r2_sec  <= r1_sec;
            r3_t1   <= TW'($signed({1'b0, r2_m})) * TW'(r2_u1);
            r3_t2   <= TW'($signed({1'b0, r2_m})) * TW'(r2_u2);
            r3_sec  <= r2_sec;
            r4_t1   <= SW'(r3_t1);
            r4_t2   <= SW'(r3_t2);
            r4_t12  <= SW'(r3_t1) + SW'(r3_t2);
            r4_sec  <= r3_sec;
            r5_t1   <= r4_t1;
            r5_t2   <= r4_t2;
            r5_t12  <= r4_t12;
            r5_h    <= w_t0 >>> 1;
            r5_over <= (w_t0 < 0);
            r5_sec  <= r4_sec;
            r6_a    <= to_duty(w_a);
            r6_b    <= to_duty(w_b);
            r6_c    <= to_duty(w_c);
            r6_sec  <= w_sec;
            r6_over <= r5_over;
        end
    end

    assign o_valid  = r6_valid;
    assign o_duty_a = r6_a;
    assign o_duty_b = r6_b;
    assign o_duty_c = r6_c;
    assign o_sector = r6_sec;
    assign o_over   = r6_over;

endmodule

// ----- rtl/space_vector_pwm_duty_core.sv -----
// Space vector PWM duty generator. Takes a q/d voltage command (signed Q8.8) and an
// electrical angle (turn fraction) and returns three centered phase duties, the sector
// and an overmodulation flag, one result per transaction. Fully pipelined: a new
// transaction is taken every cycle while the output is not stalled, and each one
// passes two CORDIC pipelines of one stage per iteration plus the multiply
// stages. A stall on the output freezes the whole pipeline. The supply reciprocal
// register is written directly and must only change while the pipeline is empty.
module space_vector_pwm_duty_core #(
    parameter int VOLT_BITS     = svpwm_pkg::VOLT_BITS_DEF,
    parameter int ANGLE_BITS    = svpwm_pkg::ANGLE_BITS_DEF,
    parameter int DUTY_BITS     = svpwm_pkg::DUTY_BITS_DEF,
    parameter int CORDIC_STAGES = svpwm_pkg::CORDIC_STAGES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [VOLT_BITS-1:0]      i_volt_q,
    input  logic signed [VOLT_BITS-1:0]      i_volt_d,
    input  logic [ANGLE_BITS-1:0]            i_elec_angle,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [DUTY_BITS-1:0]             o_duty_a,
    output logic [DUTY_BITS-1:0]             o_duty_b,
    output logic [DUTY_BITS-1:0]             o_duty_c,
    output logic [2:0]                       o_sector_index,
    output logic                             o_overmodulated,
    input  logic                             i_cfg_we,
    input  logic [svpwm_pkg::RECIP_BITS-1:0] i_cfg_data
);

    logic [svpwm_pkg::RECIP_BITS-1:0] r_recip;

    logic                        w_en;
    logic                        v_valid, v_dz;
    logic signed [VOLT_BITS-1:0] v_vq;
    logic [ANGLE_BITS-1:0]       v_th;
    logic [VOLT_BITS+9:0]        v_x;
    logic [31:0]                 v_z;
    logic                        a_valid;
    logic [VOLT_BITS+9:0]        a_m;
    logic [2:0]                  a_sec;
    logic [29:0]                 a_phi;
    logic                        c_valid;
    logic signed [32:0]          c_cos, c_sin;
    logic [VOLT_BITS+9:0]        c_m;
    logic [2:0]                  c_sec;

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recip <= svpwm_pkg::RECIP_RESET;
        end else if (i_cfg_we) begin
            r_recip <= i_cfg_data;
        end
    end

    svpwm_vec_cordic #(
        .VOLT_BITS  (VOLT_BITS),
        .ANGLE_BITS (ANGLE_BITS),
        .STAGES     (CORDIC_STAGES)
    ) u_vec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in_valid),
        .i_volt_q (i_volt_q),
        .i_volt_d (i_volt_d),
        .i_theta  (i_elec_angle),
        .o_valid  (v_valid),
        .o_d_zero (v_dz),
        .o_volt_q (v_vq),
        .o_theta  (v_th),
        .o_x      (v_x),
        .o_z      (v_z)
    );

    svpwm_angle #(
        .VOLT_BITS  (VOLT_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_angle (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (v_valid),
        .i_d_zero (v_dz),
        .i_volt_q (v_vq),
        .i_theta  (v_th),
        .i_x      (v_x),
        .i_z      (v_z),
        .i_recip  (r_recip),
        .o_valid  (a_valid),
        .o_m      (a_m),
        .o_sector (a_sec),
        .o_phi    (a_phi)
    );

    svpwm_rot_cordic #(
        .VOLT_BITS (VOLT_BITS),
        .STAGES    (CORDIC_STAGES)
    ) u_rot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (a_valid),
        .i_phi    (a_phi),
        .i_m      (a_m),
        .i_sector (a_sec),
        .o_valid  (c_valid),
        .o_cos    (c_cos),
        .o_sin    (c_sin),
        .o_m      (c_m),
        .o_sector (c_sec)
    );

    svpwm_duty_calc #(
        .VOLT_BITS (VOLT_BITS),
        .DUTY_BITS (DUTY_BITS)
    ) u_duty (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (c_valid),
        .i_cos    (c_cos),
        .i_sin    (c_sin),
        .i_m      (c_m),
        .i_sector (c_sec),
        .o_valid  (o_out_valid),
        .o_duty_a (o_duty_a),
        .o_duty_b (o_duty_b),
        .o_duty_c (o_duty_c),
        .o_sector (o_sector_index),
        .o_over   (o_overmodulated)
    );

`ifndef SYNTH
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sector_index <= 3'd5))
        else $error("sector out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_recip_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_recip == svpwm_pkg::RECIP_RESET))
        else $error("supply reciprocal not restored by reset");
`endif

endmodule

// ----- tb/testbench.sv -----
module testbench;
    import svpwm_pkg::*;

    localparam int NSTG = 16;
    localparam int LATENCY = 2 * NSTG + 11;
    localparam int RAND_ITEMS = 1800;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [15:0] vq;
        logic signed [15:0] vd;
        logic [15:0]        ang;
    } t_cmd;

    typedef struct packed {
        logic [15:0] da;
        logic [15:0] db;
        logic [15:0] dc;
        t_sector     sec;
        logic        ovm;
    } t_duty;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic signed [15:0] volt_q;
    logic signed [15:0] volt_d;
    logic [15:0] elec_angle;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [2:0]  sector_index;
    logic        overmodulated;
    logic        cfg_we;
    logic [15:0] cfg_data;
    logic        in_ready_seen;

    t_cmd  cmd_q[$];
    t_duty duty_expected[$];
    logic [15:0] recip;
    int    errors;
    longint cycles;
    bit    calm;
    int    in_idle_pct;
    int    out_idle_pct;

    space_vector_pwm_duty_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_volt_q(volt_q), .i_volt_d(volt_d), .i_elec_angle(elec_angle),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_duty_a(duty_a), .o_duty_b(duty_b), .o_duty_c(duty_c),
        .o_sector_index(sector_index), .o_overmodulated(overmodulated),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint sra(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [15:0] clamp_duty(longint v);
        longint q;
        q = sra(v, 16);
        if (q < 0) return 16'd0;
        if (q > 65535) return 16'hFFFF;
        return q[15:0];
    endfunction

    function automatic t_duty svpwm_duty(t_cmd c, logic [15:0] rc);
        t_duty r;
        longint x, y, dx, dy, m, zr, cs, sn, u1, u2, t1, t2, t0, h, a, b, cc, mag;
        logic [31:0] z, theta;
        logic [63:0] t6;
        int sec;
        theta = {c.ang, 16'h0};
        if (c.vd != 0) begin
            x = longint'(c.vd) * 256;
            y = longint'(c.vq) * 256;
            z = 32'h0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = TURN_HALF;
            end
            for (int i = 0; i < NSTG; i++) begin
                dx = sra(y, i);
                dy = sra(x, i);
                if (y > 0) begin
                    x += dx; y -= dy; z += atan_turn(5'(i));
                end else begin
                    x -= dx; y += dy; z -= atan_turn(5'(i));
                end
            end
            if (x < 0) x = 0;
            mag = (x * 39797) >>> 24;
            theta += z;
        end else if (c.vq >= 0) begin
            mag = longint'(c.vq);
            theta += TURN_QUARTER;
        end else begin
            mag = -longint'(c.vq);
            theta += TURN_3QUARTER;
        end
        m = (mag * longint'(rc)) >>> 8;
        t6 = {32'h0, theta} * 64'd6;
        sec = int'(t6[34:32]);
        zr = longint'({32'h0, t6[31:0]}) / 6;
        cs = 652032874;
        sn = 0;
        for (int i = 0; i < NSTG; i++) begin
            dx = sra(sn, i);
            dy = sra(cs, i);
            if (zr >= 0) begin
                cs -= dx; sn += dy; zr -= longint'(atan_turn(5'(i)));
            end else begin
                cs += dx; sn -= dy; zr += longint'(atan_turn(5'(i)));
            end
        end
        u1 = sra(64'sd1610612736 * cs - 64'sd929887697 * sn + (64'sd1 <<< 43), 44);
        u2 = sra(64'sd1859775393 * sn + (64'sd1 <<< 43), 44);
        t1 = m * u1;
        t2 = m * u2;
        t0 = (64'sd1 <<< 32) - t1 - t2;
        h = sra(t0, 1);
        case (sec)
            0: begin a = t1 + t2 + h; b = t2 + h; cc = h; end
            1: begin a = t1 + h; b = t1 + t2 + h; cc = h; end
            2: begin a = h; b = t1 + t2 + h; cc = t2 + h; end
            3: begin a = h; b = t1 + h; cc = t1 + t2 + h; end
            4: begin a = t2 + h; b = h; cc = t1 + t2 + h; end
            default: begin a = t1 + t2 + h; b = h; cc = t1 + h; sec = 5; end
        endcase
        r.da = clamp_duty(a);
        r.db = clamp_duty(b);
        r.dc = clamp_duty(cc);
        r.sec = t_sector'(sec[2:0]);
        r.ovm = (t0 < 0);
        return r;
    endfunction

    // driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready_seen) begin
            if (cmd_q.size() > 0 && (calm || $urandom_range(99) >= in_idle_pct)) begin
                in_valid   <= 1'b1;
                volt_q     <= cmd_q[0].vq;
                volt_d     <= cmd_q[0].vd;
                elec_angle <= cmd_q[0].ang;
                void'(cmd_q.pop_front());
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= calm || ($urandom_range(99) >= out_idle_pct);
    end

    // accept tracking and prediction at the rising edge
    always @(posedge clk) begin
        in_ready_seen <= 1'b0;
        if (rst_n && in_valid && in_ready) begin
            in_ready_seen <= 1'b1;
            duty_expected.push_back(svpwm_duty('{volt_q, volt_d, elec_angle}, recip));
        end
    end

    // monitor
    always @(posedge clk) begin
        t_duty exp_r;
        cycles <= cycles + 1;
        if (rst_n && out_valid && out_ready) begin
            if (duty_expected.size() == 0) begin
                $display("%0t: unexpected transaction a=%h b=%h c=%h", $time,
                         duty_a, duty_b, duty_c);
                errors++;
            end else begin
                exp_r = duty_expected.pop_front();
                if (exp_r.da !== duty_a) begin
                    $display("%0t: duty_a expected %h actual %h", $time, exp_r.da, duty_a);
                    errors++;
                end
                if (exp_r.db !== duty_b) begin
                    $display("%0t: duty_b expected %h actual %h", $time, exp_r.db, duty_b);
                    errors++;
                end
                if (exp_r.dc !== duty_c) begin
                    $display("%0t: duty_c expected %h actual %h", $time, exp_r.dc, duty_c);
                    errors++;
                end
                if (exp_r.sec !== sector_index) begin
                    $display("%0t: sector expected %0d actual %0d", $time, exp_r.sec,
                             sector_index);
                    errors++;
                end
                if (exp_r.ovm !== overmodulated) begin
                    $display("%0t: overmod expected %b actual %b", $time, exp_r.ovm,
                             overmodulated);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL space_vector_pwm_duty_core");
            $finish;
        end
    end

    task automatic add_cmd(int vq, int vd, int ang);
        t_cmd c;
        c.vq = vq[15:0];
        c.vd = vd[15:0];
        c.ang = ang[15:0];
        cmd_q.push_back(c);
    endtask

    task automatic drain();
        while (cmd_q.size() > 0 || in_valid || duty_expected.size() > 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_recip(logic [15:0] v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        recip    <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic random_block(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(9);
            if (k == 0)
                add_cmd($urandom, 0, $urandom);
            else if (k < 4)
                add_cmd($urandom, $urandom, $urandom);
            else
                add_cmd($urandom_range(8000) - 4000, $urandom_range(8000) - 4000, $urandom);
        end
    endtask

    initial begin
        logic [15:0] recips[5];
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        volt_q = '0;
        volt_d = '0;
        elec_angle = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        recip = RECIP_RESET;
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        in_idle_pct = 14;
        out_idle_pct = 14;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero command, extremes, sector edges, overmodulation
        add_cmd(0, 0, 0);
        add_cmd(0, 0, 16'hFFFF);
        add_cmd(32767, 0, 0);
        add_cmd(-32768, 0, 0);
        add_cmd(0, 32767, 16'h8000);
        add_cmd(0, -32768, 16'h4000);
        add_cmd(-32768, -32768, 16'hFFFF);
        add_cmd(32767, 32767, 16'h5555);
        add_cmd(-1, 1, 1);
        add_cmd(1, -1, 16'h2AAA);
        add_cmd(256, 0, 16'hAAAA);
        for (int s = 0; s < 6; s++) add_cmd(2000, 300, s * 10923);
        add_cmd(768, 0, 16'h1555);
        drain();

        recips[0] = 16'd0;
        recips[1] = 16'hFFFF;
        recips[2] = 16'd100;
        recips[3] = 16'd20000;
        recips[4] = RECIP_RESET;
        for (int p = 0; p < 5; p++) begin
            write_recip(recips[p]);
            calm = (p == 2);
            add_cmd(32767, 0, 0);
            add_cmd(-32768, 32767, 16'h7FFF);
            random_block(RAND_ITEMS / 5);
            drain();
        end

        if (errors == 0) begin
            $display("PASS space_vector_pwm_duty_core");
        end else begin
            $display("FAIL space_vector_pwm_duty_core");
        end
        $finish;
    end
endmodule
